/* design/half_open_range_tracker_defines.svh */
// Assertion macros for the half-open range tracker.
// Used by half_open_range_tracker.sv; relies on aclk and aresetn in scope.
`ifndef HALF_OPEN_RANGE_TRACKER_DEFINES_SVH
`define HALF_OPEN_RANGE_TRACKER_DEFINES_SVH

// Plain invariant, checked at every edge out of reset.
`define HORT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define HORT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HORT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/hort_pkg.sv */
// Shared types and constants for the half-open range tracker.
// No dependencies; imported by hort_span_cmp and half_open_range_tracker.
`default_nettype none

package hort_pkg;

    localparam int MAX_SPANS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Stream field layout, lowest bit first
    localparam int CMD_W      = 2;
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int SPANS_W    = 5;
    localparam int CMD_LSB    = 0;
    localparam int START_LSB  = CMD_LSB + CMD_W;
    localparam int END_LSB    = START_LSB + FIELD_W;
    localparam int S_FIELDS_W = END_LSB + FIELD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int COV_LSB    = 0;
    localparam int STATUS_LSB = COV_LSB + 1;
    localparam int SPANS_LSB  = STATUS_LSB + STATUS_W;
    localparam int M_FIELDS_W = SPANS_LSB + SPANS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Flags from the shared compare unit; operand [lo, hi) is one stored span while sweeping
    typedef struct packed {
        logic lo_le_e;
        logic s_le_hi;
        logic lo_lt_mlo;
        logic hi_gt_mhi;
        logic lo_le_s;
        logic lo_lt_s;
        logic hi_ge_e;
        logic hi_gt_e;
    } cmp_flags_t;

endpackage

`default_nettype wire

/* design/hort_span_ram.sv */
// Span table storage: one write port, one read port, registered read data.
// No package dependencies.
`default_nettype none

module hort_span_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/hort_span_cmp.sv */
// Shared compare unit: tests one span against the request and the merge bounds.
// Depends on hort_pkg for the flag struct.
`default_nettype none

module hort_span_cmp #(
    parameter int VALUE_BITS = hort_pkg::VALUE_BITS_DEF
) (
    input  wire logic [VALUE_BITS-1:0] op_lo,
    input  wire logic [VALUE_BITS-1:0] op_hi,
    input  wire logic [VALUE_BITS-1:0] req_start,
    input  wire logic [VALUE_BITS-1:0] req_end,
    input  wire logic [VALUE_BITS-1:0] merge_lo,
    input  wire logic [VALUE_BITS-1:0] merge_hi,
    output hort_pkg::cmp_flags_t       flags
);

    import hort_pkg::*;

    always_comb begin
        flags.lo_le_e   = (op_lo <= req_end);
        flags.s_le_hi   = (req_start <= op_hi);
        flags.lo_lt_mlo = (op_lo < merge_lo);
        flags.hi_gt_mhi = (op_hi > merge_hi);
        flags.lo_le_s   = (op_lo <= req_start);
        flags.lo_lt_s   = (op_lo < req_start);
        flags.hi_ge_e   = (op_hi >= req_end);
        flags.hi_gt_e   = (op_hi > req_end);
    end

endmodule

`default_nettype wire

/* design/half_open_range_tracker.sv */
// m_tvalid rises once a transaction has passed CHECK, SCAN (N spans stored, one table
// read per cycle), PUT_A and PUT_B where needed, and DONE; an invalid range or unused cmd
// goes from CHECK straight to DONE. One transaction at a time; s_tready returns the cycle
// after the result is loaded. A result still waiting in the output register holds the
// sequencer until it is taken. Reset (aresetn low, synchronous) empties the table; span
// contents are left as is.
`default_nettype none
`include "half_open_range_tracker_defines.svh"

module half_open_range_tracker #(
    parameter int MAX_SPANS  = hort_pkg::MAX_SPANS_DEF,
    parameter int VALUE_BITS = hort_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[1:0], range_start[33:2], range_end[65:34], zero pad
    input  wire logic [hort_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // fully_covered[0], status[2:1], spans_in_use[7:3]
    output logic      [hort_pkg::M_TDATA_W-1:0] m_tdata
);

    import hort_pkg::*;

    localparam int IDX_W = $clog2(MAX_SPANS);
    localparam int CNT_W = $clog2(MAX_SPANS + 1);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        SCAN,
        PUT_A,
        PUT_B,
        DONE
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] start_reg, start_next, end_reg, end_next;
    logic [VALUE_BITS-1:0] mlo_reg, mlo_next, mhi_reg, mhi_next;
    logic [VALUE_BITS-1:0] pa_lo_reg, pa_lo_next, pa_hi_reg, pa_hi_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next, sc_reg, sc_next, wr_ptr_reg, wr_ptr_next;
    logic                  rd_valid_reg, rd_valid_next, hit_reg, hit_next;
    logic                  cov_reg, cov_next, put_b_reg, put_b_next;
    status_t               status_reg, status_next;
    logic                  out_valid_reg, out_valid_next, out_cov_reg, out_cov_next;
    status_t               out_status_reg, out_status_next;
    logic [SPANS_W-1:0]    out_spans_reg, out_spans_next;

    logic [FIELD_W+VALUE_BITS-1:0] in_start_ext, in_end_ext;
    logic [CNT_W+SPANS_W-1:0]      cnt_ext;
    logic [CNT_W:0]                total;
    logic                          keep_l, keep_r, scan_end;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [2*VALUE_BITS-1:0] ram_wdata, ram_rdata;
    logic [VALUE_BITS-1:0]   op_lo, op_hi, ram_lo, ram_hi;
    cmp_flags_t              flags;

    hort_span_ram #(
        .WIDTH  (2 * VALUE_BITS),
        .DEPTH  (MAX_SPANS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hort_span_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .op_lo     (op_lo),
        .op_hi     (op_hi),
        .req_start (start_reg),
        .req_end   (end_reg),
        .merge_lo  (mlo_reg),
        .merge_hi  (mhi_reg),
        .flags     (flags)
    );

    assign ram_lo = ram_rdata[VALUE_BITS-1:0];
    assign ram_hi = ram_rdata[2*VALUE_BITS-1:VALUE_BITS];

    // Fields are resized to the value width (zero extend or truncate)
    assign in_start_ext = {{VALUE_BITS{1'b0}}, s_tdata[START_LSB +: FIELD_W]};
    assign in_end_ext   = {{VALUE_BITS{1'b0}}, s_tdata[END_LSB +: FIELD_W]};
    assign cnt_ext      = {{SPANS_W{1'b0}}, cnt_reg};

    // Compare unit operand: end bound for the range check, table entry while
    // sweeping, merged bounds for the final decision
    always_comb begin
        if (state_reg == CHECK) begin
            op_lo = end_reg;
            op_hi = mhi_reg;
        end else if (rd_valid_reg) begin
            op_lo = ram_lo;
            op_hi = ram_hi;
        end else begin
            op_lo = mlo_reg;
            op_hi = mhi_reg;
        end
    end

    assign scan_end = (sc_reg == cnt_reg) && !rd_valid_reg;
    assign keep_l   = hit_reg && flags.lo_lt_s;
    assign keep_r   = hit_reg && flags.hi_gt_e;
    assign total    = {1'b0, wr_ptr_reg} + (CNT_W+1)'(keep_l) + (CNT_W+1)'(keep_r);

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        m_tdata[COV_LSB]                 = out_cov_reg;
        m_tdata[STATUS_LSB +: STATUS_W]  = out_status_reg;
        m_tdata[SPANS_LSB +: SPANS_W]    = out_spans_reg;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        mlo_next        = mlo_reg;
        mhi_next        = mhi_reg;
        pa_lo_next      = pa_lo_reg;
        pa_hi_next      = pa_hi_reg;
        cnt_next        = cnt_reg;
        sc_next         = sc_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_valid_next   = 1'b0;
        hit_next        = hit_reg;
        cov_next        = cov_reg;
        put_b_next      = put_b_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cov_next    = out_cov_reg;
        out_status_next = out_status_reg;
        out_spans_next  = out_spans_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = sc_reg[IDX_W-1:0];

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = cmd_t'(s_tdata[CMD_LSB +: CMD_W]);
                    start_next = in_start_ext[VALUE_BITS-1:0];
                    end_next   = in_end_ext[VALUE_BITS-1:0];
                    state_next = CHECK;
                end
            end
            CHECK: begin
                mlo_next    = start_reg;
                mhi_next    = end_reg;
                hit_next    = 1'b0;
                cov_next    = 1'b0;
                sc_next     = '0;
                wr_ptr_next = '0;
                status_next = ST_OK;
                if (cmd_reg == CMD_NOP) begin
                    state_next = DONE;
                end else if (flags.lo_le_s) begin
                    // end <= start
                    status_next = ST_INVALID;
                    state_next  = DONE;
                end else begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                if (sc_reg < cnt_reg) begin
                    rd_valid_next = 1'b1;
                    sc_next       = sc_reg + CNT_W'(1);
                end
                if (rd_valid_reg) begin
                    if (cmd_reg == CMD_QUERY) begin
                        if (flags.lo_le_s && flags.hi_ge_e) begin
                            cov_next = 1'b1;
                        end
                    end else if (flags.lo_le_e && flags.s_le_hi) begin
                        hit_next = 1'b1;
                        if (flags.lo_lt_mlo) begin
                            mlo_next = ram_lo;
                        end
                        if (flags.hi_gt_mhi) begin
                            mhi_next = ram_hi;
                        end
                    end else begin
                        // untouched span moves down over the merged ones
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (scan_end) begin
                    put_b_next = 1'b0;
                    pa_lo_next = mlo_reg;
                    pa_hi_next = mhi_reg;
                    case (cmd_reg)
                        CMD_ADD: begin
                            if (!hit_reg && (cnt_reg == CNT_W'(MAX_SPANS))) begin
                                status_next = ST_FULL;
                                state_next  = DONE;
                            end else begin
                                cnt_next   = wr_ptr_reg + CNT_W'(1);
                                state_next = PUT_A;
                            end
                        end
                        CMD_REMOVE: begin
                            if (total > (CNT_W+1)'(MAX_SPANS)) begin
                                // only one span was taken out: put it back whole
                                status_next = ST_FULL;
                                state_next  = PUT_A;
                            end else begin
                                cnt_next = total[CNT_W-1:0];
                                if (keep_l) begin
                                    pa_hi_next = start_reg;
                                    put_b_next = keep_r;
                                    state_next = PUT_A;
                                end else if (keep_r) begin
                                    pa_lo_next = end_reg;
                                    state_next = PUT_A;
                                end else begin
                                    state_next = DONE;
                                end
                            end
                        end
                        default: begin
                            state_next = DONE;
                        end
                    endcase
                end
            end
            PUT_A: begin
                ram_we      = 1'b1;
                ram_wdata   = {pa_hi_reg, pa_lo_reg};
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                state_next  = put_b_reg ? PUT_B : DONE;
            end
            PUT_B: begin
                ram_we     = 1'b1;
                ram_wdata  = {mhi_reg, end_reg};
                state_next = DONE;
            end
            DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_cov_next    = cov_reg;
                    out_status_next = status_reg;
                    out_spans_next  = cnt_ext[SPANS_W-1:0];
                    state_next      = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            mlo_reg        <= mlo_next;
            mhi_reg        <= mhi_next;
            pa_lo_reg      <= pa_lo_next;
            pa_hi_reg      <= pa_hi_next;
            sc_reg         <= sc_next;
            wr_ptr_reg     <= wr_ptr_next;
            hit_reg        <= hit_next;
            cov_reg        <= cov_next;
            put_b_reg      <= put_b_next;
            status_reg     <= status_next;
            out_cov_reg    <= out_cov_next;
            out_status_reg <= out_status_next;
            out_spans_reg  <= out_spans_next;
        end
    end

    `HORT_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_SPANS), "span count above capacity")
    `HORT_ASSERT_IMPL(a_compact_order, state_reg == SCAN, wr_ptr_reg <= sc_reg, "compaction overtook the read pointer")
    `HORT_ASSERT_IMPL(a_write_range, ram_we, wr_ptr_reg < CNT_W'(MAX_SPANS), "table write beyond capacity")
    `HORT_ASSERT_IMPL(a_read_in_scan, rd_valid_reg, state_reg == SCAN, "table read outside the sweep")
    `HORT_ASSERT_NEXT(a_result_issue, (state_reg == DONE) && (!out_valid_reg || m_tready), out_valid_reg && (state_reg == IDLE), "result not issued")

endmodule

`default_nettype wire
